[rtl/core/sync_type_xor_frame_parser_assert.svh]
// assertion macros of the frame parser rtl, used by the back end
// expects i_clk and i_rst_n in the scope of each use
`ifndef SYNC_TYPE_XOR_FRAME_PARSER_ASSERT_SVH
`define SYNC_TYPE_XOR_FRAME_PARSER_ASSERT_SVH

// same-cycle implication
`define SXFP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sxfp assertion failed");

// next-cycle implication
`define SXFP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sxfp assertion failed");

`endif

[rtl/core/sxfp_pkg.sv]
// shared types, constants and helpers of the sync framed parser
// no dependencies
`default_nettype none

package sxfp_pkg;

    localparam int MAX_FRAME = 32;
    localparam int QDEPTH    = 2;

    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int CFG_LEN_W = 6;
    localparam int LEN_W     = $clog2(MAX_FRAME + 1);
    localparam int IDX_W     = $clog2(MAX_FRAME);
    localparam int SLOT_W    = $clog2(QDEPTH);
    localparam int CNT_W     = $clog2(QDEPTH + 1);
    localparam int MEM_AW    = SLOT_W + IDX_W;

    localparam int NUM_REGS  = 6;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam int ADDR_W    = REG_IDX_W + 2;
    localparam int APB_W     = 32;

    localparam logic [REG_IDX_W-1:0] REG_SYNC        = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_CONTROL_TYP = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_CONTROL_LEN = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_CONFIG_TYP  = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_CONFIG_LEN  = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_DUMP_TYP    = REG_IDX_W'(5);

    localparam logic [KIND_W-1:0] KIND_CONTROL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CONFIG  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DUMP    = 2'd2;

    localparam logic [BYTE_W-1:0]    RST_SYNC        = 8'hAA;
    localparam logic [BYTE_W-1:0]    RST_CONTROL_TYP = 8'd0;
    localparam logic [CFG_LEN_W-1:0] RST_CONTROL_LEN = 6'd1;
    localparam logic [BYTE_W-1:0]    RST_CONFIG_TYP  = 8'd1;
    localparam logic [CFG_LEN_W-1:0] RST_CONFIG_LEN  = 6'd1;
    localparam logic [BYTE_W-1:0]    RST_DUMP_TYP    = 8'd2;

    typedef struct packed {
        logic [BYTE_W-1:0]    sync_byte;
        logic [BYTE_W-1:0]    control_type_code;
        logic [CFG_LEN_W-1:0] control_length;
        logic [BYTE_W-1:0]    config_type_code;
        logic [CFG_LEN_W-1:0] config_length;
        logic [BYTE_W-1:0]    dump_type_code;
    } t_cfg;

    // write into the frame store
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] data;
    } t_wr;

    // one finished frame handed to the emitter
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  len;
        logic              bad;
        logic [BYTE_W-1:0] xsum;
    } t_desc;

    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_push;

    typedef struct packed {
        logic              full;
        logic [SLOT_W-1:0] wslot;
    } t_qstat;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [CFG_LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        if (len == '0) begin
            res = LEN_W'(1);
        end else if (int'(len) > MAX_FRAME) begin
            res = LEN_W'(MAX_FRAME);
        end else begin
            res = LEN_W'(len);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/core/sxfp_rx_if.sv]
// byte input channel of the frame parser
// depends on sxfp_pkg
`default_nettype none

interface sxfp_rx_if import sxfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_value;

    modport source (output valid, output rx_value, input ready);
    modport sink (input valid, input rx_value, output ready);
endinterface

`default_nettype wire

[rtl/core/sxfp_frame_if.sv]
// result channel of the frame parser
// depends on sxfp_pkg
`default_nettype none

interface sxfp_frame_if import sxfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic [KIND_W-1:0] frame_kind;
    logic              checksum_bad;
    logic              last_of_frame;

    modport source (output valid, output frame_byte, output frame_kind,
                    output checksum_bad, output last_of_frame, input ready);
    modport sink (input valid, input frame_byte, input frame_kind,
                  input checksum_bad, input last_of_frame, output ready);
endinterface

`default_nettype wire

[rtl/core/sync_type_xor_frame_parser.sv]
// sync byte framed parser with xor checksum: the checksum byte transfer registers the frame
// in the queue, then its results leave the output register one per cycle under no backpressure
// input takes one byte per cycle; it stalls only while two finished frames wait
// in the emitter queue, whose double frame store sets that limit
// i_rst_n is synchronous, active low; it clears control state and the queue,
// the frame store keeps its contents and needs no clearing pass
`default_nettype none

module sync_type_xor_frame_parser import sxfp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sxfp_rx_if.sink           i_rx,
    sxfp_frame_if.source      o_frame,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready
);

    t_cfg   cfg;
    t_wr    wr;
    t_push  push;
    t_qstat qstat;

    sxfp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sxfp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_cfg   (cfg),
        .i_qstat (qstat),
        .o_wr    (wr),
        .o_push  (push)
    );

    sxfp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_push  (push),
        .o_qstat (qstat),
        .o_frame (o_frame)
    );

endmodule

`default_nettype wire

[rtl/core/sxfp_regs.sv]
// apb configuration registers of the frame parser
// depends on sxfp_pkg
`default_nettype none

module sxfp_regs import sxfp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_byte         <= RST_SYNC;
            r_cfg.control_type_code <= RST_CONTROL_TYP;
            r_cfg.control_length    <= RST_CONTROL_LEN;
            r_cfg.config_type_code  <= RST_CONFIG_TYP;
            r_cfg.config_length     <= RST_CONFIG_LEN;
            r_cfg.dump_type_code    <= RST_DUMP_TYP;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SYNC:        r_cfg.sync_byte         <= pwdata[BYTE_W-1:0];
                REG_CONTROL_TYP: r_cfg.control_type_code <= pwdata[BYTE_W-1:0];
                REG_CONTROL_LEN: r_cfg.control_length    <= pwdata[CFG_LEN_W-1:0];
                REG_CONFIG_TYP:  r_cfg.config_type_code  <= pwdata[BYTE_W-1:0];
                REG_CONFIG_LEN:  r_cfg.config_length     <= pwdata[CFG_LEN_W-1:0];
                REG_DUMP_TYP:    r_cfg.dump_type_code    <= pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SYNC:        prdata = APB_W'(r_cfg.sync_byte);
            REG_CONTROL_TYP: prdata = APB_W'(r_cfg.control_type_code);
            REG_CONTROL_LEN: prdata = APB_W'(r_cfg.control_length);
            REG_CONFIG_TYP:  prdata = APB_W'(r_cfg.config_type_code);
            REG_CONFIG_LEN:  prdata = APB_W'(r_cfg.config_length);
            REG_DUMP_TYP:    prdata = APB_W'(r_cfg.dump_type_code);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[rtl/core/sxfp_front.sv]
// front end: sync hunt, type check, byte capture and checksum compare
// depends on sxfp_pkg and sxfp_rx_if
`default_nettype none

module sxfp_front import sxfp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    sxfp_rx_if.sink i_rx,
    input  t_cfg   i_cfg,
    input  t_qstat i_qstat,
    output t_wr    o_wr,
    output t_push  o_push
);

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_TYPE = 4'b0010,
        PH_BODY = 4'b0100,
        PH_SUM  = 4'b1000
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [LEN_W-1:0]  r_fill, n_fill;
    logic [LEN_W-1:0]  r_want, n_want;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [BYTE_W-1:0] r_xor, n_xor;
    logic              acc;
    logic [BYTE_W-1:0] b;
    logic [LEN_W-1:0]  fill_inc;

    assign i_rx.ready = !i_qstat.full;
    assign acc        = i_rx.valid && i_rx.ready;
    assign b          = i_rx.rx_value;
    assign fill_inc   = r_fill + LEN_W'(1);

    always_comb begin
        n_phase = r_phase;
        n_fill  = r_fill;
        n_want  = r_want;
        n_kind  = r_kind;
        n_xor   = r_xor;
        o_wr    = '0;
        o_push  = '0;
        if (acc) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (b == i_cfg.sync_byte) begin
                        n_phase = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    n_phase = PH_HUNT;
                    priority if (b == i_cfg.control_type_code) begin
                        n_kind = KIND_CONTROL;
                        n_want = clamp_len(i_cfg.control_length);
                    end else if (b == i_cfg.config_type_code) begin
                        n_kind = KIND_CONFIG;
                        n_want = clamp_len(i_cfg.config_length);
                    end else if (b == i_cfg.dump_type_code) begin
                        n_kind = KIND_DUMP;
                        n_want = LEN_W'(1);
                    end else begin
                        n_kind = r_kind;
                    end
                    if (b == i_cfg.control_type_code || b == i_cfg.config_type_code ||
                        b == i_cfg.dump_type_code) begin
                        o_wr.en   = 1'b1;
                        o_wr.slot = i_qstat.wslot;
                        o_wr.idx  = '0;
                        o_wr.data = b;
                        n_fill    = LEN_W'(1);
                        n_xor     = b;
                        n_phase   = (n_want == LEN_W'(1)) ? PH_SUM : PH_BODY;
                    end
                end
                PH_BODY: begin
                    o_wr.en   = 1'b1;
                    o_wr.slot = i_qstat.wslot;
                    o_wr.idx  = r_fill[IDX_W-1:0];
                    o_wr.data = b;
                    n_fill    = fill_inc;
                    n_xor     = r_xor ^ b;
                    if (fill_inc >= r_want) begin
                        n_phase = PH_SUM;
                    end
                end
                PH_SUM: begin
                    o_push.valid     = 1'b1;
                    o_push.desc.kind = r_kind;
                    o_push.desc.len  = r_fill;
                    o_push.desc.bad  = (r_xor != b);
                    o_push.desc.xsum = r_xor;
                    n_phase          = PH_HUNT;
                end
                default: n_phase = PH_HUNT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_fill  <= '0;
            r_want  <= '0;
            r_kind  <= KIND_CONTROL;
            r_xor   <= '0;
        end else begin
            r_phase <= n_phase;
            r_fill  <= n_fill;
            r_want  <= n_want;
            r_kind  <= n_kind;
            r_xor   <= n_xor;
        end
    end

endmodule

`default_nettype wire

[rtl/core/sxfp_back.sv]
// back end: frame queue, double frame store and result emitter
// depends on sxfp_pkg, sxfp_frame_if and the assertion macro header
`default_nettype none
`include "sync_type_xor_frame_parser_assert.svh"

module sxfp_back import sxfp_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_wr             i_wr,
    input  t_push           i_push,
    output t_qstat          o_qstat,
    sxfp_frame_if.source    o_frame
);

    logic [BYTE_W-1:0] r_mem [QDEPTH*MAX_FRAME];
    t_desc             r_q [QDEPTH];
    logic [SLOT_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0]  r_cnt;
    logic [IDX_W-1:0]  r_idx;
    logic              r_ov;
    logic [BYTE_W-1:0] r_byte;
    logic [KIND_W-1:0] r_kind;
    logic              r_bad;
    logic              r_last;

    t_desc             head;
    logic              can_issue;
    logic              issue;
    logic              last_item;
    logic              pop;

    assign head      = r_q[r_rptr];
    assign can_issue = !r_ov || o_frame.ready;
    assign issue     = (r_cnt != '0) && can_issue;
    assign last_item = head.bad || ((LEN_W'(r_idx) + LEN_W'(1)) == head.len);
    assign pop       = issue && last_item;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[{i_wr.slot, i_wr.idx}] <= i_wr.data;
        end
        if (issue) begin
            r_byte <= head.bad ? head.xsum : r_mem[{r_rptr, r_idx}];
            r_kind <= head.kind;
            r_bad  <= head.bad;
            r_last <= last_item;
        end
        if (i_push.valid) begin
            r_q[r_wptr] <= i_push.desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
            r_idx  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (i_push.valid) begin
                r_wptr <= r_wptr + SLOT_W'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + SLOT_W'(1);
            end
            unique case ({i_push.valid, pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
            if (issue) begin
                r_idx <= pop ? '0 : r_idx + IDX_W'(1);
                r_ov  <= 1'b1;
            end else if (o_frame.ready) begin
                r_ov  <= 1'b0;
            end
        end
    end

    assign o_qstat.full  = (r_cnt == CNT_W'(QDEPTH));
    assign o_qstat.wslot = r_wptr;

    assign o_frame.valid         = r_ov;
    assign o_frame.frame_byte    = r_byte;
    assign o_frame.frame_kind    = r_kind;
    assign o_frame.checksum_bad  = r_bad;
    assign o_frame.last_of_frame = r_last;

    `SXFP_ASSERT_IMP(a_cnt_range, 1'b1, r_cnt <= CNT_W'(QDEPTH))
    `SXFP_ASSERT_IMP(a_no_overflow, i_push.valid, r_cnt < CNT_W'(QDEPTH))
    `SXFP_ASSERT_NXT(a_err_is_last, issue && head.bad, r_last && r_bad)

endmodule

`default_nettype wire

[tb/tb_top.sv]
// self-checking testbench for sync_type_xor_frame_parser: byte stream in, frame items out
// depends on sxfp_pkg, sxfp_rx_if, sxfp_frame_if and the parser rtl
// predicts every frame from the accepted bytes and register writes, compares in order
`timescale 1ns / 1ps

module tb_top;
    import sxfp_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_BYTES = 30;
    localparam int IDLE_PCT    = 12;

    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = REG_IDX_W'(NUM_REGS);
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = REG_IDX_W'(NUM_REGS + 1);

    typedef enum logic [1:0] {
        P_HUNT,
        P_TYPE,
        P_BODY,
        P_SUM
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [KIND_W-1:0] kind;
        logic              bad;
        logic              last;
    } t_frame_item;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_W-1:0]  pwdata;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    sxfp_rx_if    rx ();
    sxfp_frame_if fr ();

    sync_type_xor_frame_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx),
        .o_frame (fr),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // parser model state and register copy
    t_cfg              cfg = '{RST_SYNC, RST_CONTROL_TYP, RST_CONTROL_LEN,
                               RST_CONFIG_TYP, RST_CONFIG_LEN, RST_DUMP_TYP};
    t_phase            phase = P_HUNT;
    logic [BYTE_W-1:0] store [MAX_FRAME];
    logic [5:0]        fill = '0;
    logic [5:0]        want = '0;
    logic [KIND_W-1:0] kind = KIND_CONTROL;
    logic [BYTE_W-1:0] run_xor = '0;

    logic [BYTE_W-1:0] rx_bytes [$];
    t_frame_item       frame_expect [$];
    int                mismatches = 0;
    int                queued = 0;
    int                hold_req = 0;
    int                hold_ack = 0;
    int                hold_left = 0;
    logic              quiet = 1'b0;
    logic              rx_fire = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [5:0] fit_length(input logic [CFG_LEN_W-1:0] n);
        logic [5:0] res;
        if (n == '0) begin
            res = 6'd1;
        end else if (int'(n) > MAX_FRAME) begin
            res = 6'(MAX_FRAME);
        end else begin
            res = 6'(n);
        end
        return res;
    endfunction

    function automatic void parse_byte(input logic [BYTE_W-1:0] b);
        logic hit;
        int   i;
        case (phase)
            P_HUNT: begin
                if (b == cfg.sync_byte) phase = P_TYPE;
            end
            P_TYPE: begin
                hit = 1'b1;
                if (b == cfg.control_type_code) begin
                    kind = KIND_CONTROL;
                    want = fit_length(cfg.control_length);
                end else if (b == cfg.config_type_code) begin
                    kind = KIND_CONFIG;
                    want = fit_length(cfg.config_length);
                end else if (b == cfg.dump_type_code) begin
                    kind = KIND_DUMP;
                    want = 6'd1;
                end else begin
                    hit = 1'b0;
                end
                if (!hit) begin
                    phase = P_HUNT;
                end else begin
                    store[0] = b;
                    fill = 6'd1;
                    run_xor = b;
                    phase = (fill >= want) ? P_SUM : P_BODY;
                end
            end
            P_BODY: begin
                if (int'(fill) < MAX_FRAME) begin
                    store[fill] = b;
                    fill = fill + 6'd1;
                    run_xor = run_xor ^ b;
                end
                if (fill >= want) phase = P_SUM;
            end
            default: begin
                if (run_xor == b) begin
                    for (i = 0; i < int'(fill); i++) begin
                        frame_expect.push_back('{store[i], kind, 1'b0, (i + 1 == int'(fill))});
                    end
                end else begin
                    frame_expect.push_back('{run_xor, kind, 1'b1, 1'b1});
                end
                phase = P_HUNT;
            end
        endcase
    endfunction

    // byte side: model update on each accepted transfer
    always @(posedge i_clk) begin
        rx_fire <= i_rst_n && rx.valid && rx.ready;
        if (i_rst_n && rx.valid && rx.ready) parse_byte(rx.rx_value);
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!rx.valid || rx_fire)) begin
            if (rx_bytes.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                rx.valid    <= 1'b1;
                rx.rx_value <= rx_bytes.pop_front();
            end else begin
                rx.valid <= 1'b0;
            end
        end
    end

    // result side: ready with random stalls and one long hold-off
    always @(negedge i_clk) begin
        if (hold_ack != hold_req) begin
            hold_ack = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            fr.ready <= 1'b0;
        end else begin
            fr.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        t_frame_item got;
        t_frame_item exp_item;
        if (i_rst_n && fr.valid && fr.ready) begin
            got = '{fr.frame_byte, fr.frame_kind, fr.checksum_bad, fr.last_of_frame};
            if (frame_expect.size() == 0) begin
                mismatches++;
                $display("%0t: expected none, actual %h %0d %b %b",
                         $time, got.data, got.kind, got.bad, got.last);
            end else begin
                exp_item = frame_expect.pop_front();
                if (got !== exp_item) begin
                    mismatches++;
                    $display("%0t: expected %h %0d %b %b, actual %h %0d %b %b",
                             $time, exp_item.data, exp_item.kind, exp_item.bad, exp_item.last,
                             got.data, got.kind, got.bad, got.last);
                end
            end
        end
    end

    task automatic offer(input logic [BYTE_W-1:0] b);
        rx_bytes.push_back(b);
        queued++;
    endtask

    task automatic queue_frame(input logic [KIND_W-1:0] which, input bit corrupt);
        logic [BYTE_W-1:0] code;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] v;
        logic [5:0]        n;
        int                i;
        case (which)
            KIND_CONTROL: begin
                code = cfg.control_type_code;
                n = fit_length(cfg.control_length);
            end
            KIND_CONFIG: begin
                code = cfg.config_type_code;
                n = fit_length(cfg.config_length);
            end
            default: begin
                code = cfg.dump_type_code;
                n = 6'd1;
            end
        endcase
        offer(cfg.sync_byte);
        offer(code);
        sum = code;
        for (i = 1; i < int'(n); i++) begin
            v = 8'($urandom);
            offer(v);
            sum = sum ^ v;
        end
        if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
        offer(sum);
    endtask

    // wait until every byte is taken and every frame item has come back
    task automatic settle();
        do @(posedge i_clk);
        while (rx_bytes.size() != 0 || rx.valid || frame_expect.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SYNC:        cfg.sync_byte = val[BYTE_W-1:0];
            REG_CONTROL_TYP: cfg.control_type_code = val[BYTE_W-1:0];
            REG_CONTROL_LEN: cfg.control_length = val[CFG_LEN_W-1:0];
            REG_CONFIG_TYP:  cfg.config_type_code = val[BYTE_W-1:0];
            REG_CONFIG_LEN:  cfg.config_length = val[CFG_LEN_W-1:0];
            REG_DUMP_TYP:    cfg.dump_type_code = val[BYTE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_all(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] c_code,
                               input logic [CFG_LEN_W-1:0] c_len,
                               input logic [BYTE_W-1:0] f_code,
                               input logic [CFG_LEN_W-1:0] f_len,
                               input logic [BYTE_W-1:0] d_code);
        reg_write(REG_SYNC, APB_W'(s));
        reg_write(REG_CONTROL_TYP, APB_W'(c_code));
        reg_write(REG_CONTROL_LEN, APB_W'(c_len));
        reg_write(REG_CONFIG_TYP, APB_W'(f_code));
        reg_write(REG_CONFIG_LEN, APB_W'(f_len));
        reg_write(REG_DUMP_TYP, APB_W'(d_code));
    endtask

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int                phase_no;
        int                pick;
        logic [BYTE_W-1:0] c_code;
        logic [BYTE_W-1:0] unk;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        rx.valid    = 1'b0;
        rx.rx_value = '0;
        fr.ready    = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: each kind, a bad checksum, an unknown type equal to sync
        queue_frame(KIND_CONTROL, 1'b0);
        queue_frame(KIND_CONFIG, 1'b0);
        queue_frame(KIND_DUMP, 1'b0);
        offer(RST_SYNC);
        offer(RST_CONTROL_TYP);
        offer(8'h5A);
        offer(RST_SYNC);
        offer(RST_SYNC);
        offer(RST_DUMP_TYP);
        offer(RST_DUMP_TYP);
        queue_frame(KIND_DUMP, 1'b0);
        settle();

        // zero and saturating lengths, equal codes, writes past the register list
        program_all(8'hFF, 8'h55, 6'd0, 8'h55, 6'd63, 8'h00);
        reg_write(REG_SPARE_LO, 32'hFFFF_FFFF);
        reg_write(REG_SPARE_HI, 32'h0000_0003);
        queue_frame(KIND_CONFIG, 1'b0);
        queue_frame(KIND_DUMP, 1'b0);
        settle();

        // length change in the middle of a frame, sync value as payload
        reg_write(REG_CONTROL_LEN, 32'd3);
        offer(8'hFF);
        offer(8'h55);
        offer(8'hFF);
        settle();
        reg_write(REG_CONTROL_LEN, 32'd1);
        offer(8'h11);
        offer(8'h55 ^ 8'hFF ^ 8'h11);
        settle();

        for (phase_no = 0; phase_no < 5; phase_no++) begin
            if (phase_no == 2) begin
                program_all(8'($urandom), 8'h00, 6'd32, 8'hFF, 6'd63, 8'($urandom));
            end else begin
                c_code = 8'($urandom);
                program_all(8'($urandom), c_code, 6'($urandom_range(0, 6)),
                            ($urandom_range(99) < 25) ? c_code : 8'($urandom),
                            6'($urandom_range(0, 6)), 8'($urandom));
            end
            quiet = (phase_no == 1);
            if (phase_no == 3) hold_req++;
            queued = 0;
            while (queued < PHASE_BYTES) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    queue_frame(KIND_W'($urandom_range(2)), $urandom_range(99) < 15);
                end else if (pick < 78) begin
                    do unk = 8'($urandom);
                    while (unk == cfg.control_type_code || unk == cfg.config_type_code
                           || unk == cfg.dump_type_code);
                    offer(cfg.sync_byte);
                    offer(unk);
                end else if (pick < 85) begin
                    // truncated frame, the following bytes run into it
                    offer(cfg.sync_byte);
                    offer(cfg.control_type_code);
                    offer(8'($urandom));
                end else begin
                    repeat ($urandom_range(1, 4)) offer(8'($urandom));
                end
            end
            settle();
            quiet = 1'b0;
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/sxfp_pkg.sv
rtl/core/sxfp_rx_if.sv
rtl/core/sxfp_frame_if.sv
rtl/core/sxfp_regs.sv
rtl/core/sxfp_front.sv
rtl/core/sxfp_back.sv
rtl/core/sync_type_xor_frame_parser.sv
tb/tb_top.sv
